// File: hdl/ptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the power triangle calculation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

  // input field width (voltage, current, power factor)
  localparam int IN_W        = 16;
  // power result width (apparent, active, reactive)
  localparam int PWR_W       = 32;
  // width of a squared power value
  localparam int SQ_W        = 2 * PWR_W;
  // one root bit is resolved per square-root stage
  localparam int ROOT_STAGES = PWR_W;
  // partial remainder width in the square-root pipeline
  localparam int REM_W       = PWR_W + 2;

  // apparent and active power travelling alongside the root computation
  typedef struct packed {
    logic [PWR_W-1:0] active;
    logic [PWR_W-1:0] apparent;
  } ptc_pwr_t;

endpackage : ptc_pkg

// File: hdl/ptc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_front
// Four-stage multiply front end: apparent power, active power, and the
// difference of their squares that feeds the square-root pipeline.
// ----------------------------------------------------------------------------
module ptc_front
  import ptc_pkg::*;
#(
  parameter int FRACTION_BITS = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [IN_W-1:0]  up_voltage,
  input  logic [IN_W-1:0]  up_current,
  input  logic [IN_W-1:0]  up_power_factor,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [SQ_W-1:0]  dn_diff,
  output ptc_pwr_t         dn_pwr
);

  // power factor width: must hold 1.0 as well as any input code
  localparam int PF_W   = (FRACTION_BITS + 1 > IN_W) ? FRACTION_BITS + 1 : IN_W;
  localparam int PROD_W = PWR_W + PF_W;
  localparam logic [PF_W-1:0] PF_ONE = PF_W'(1) << FRACTION_BITS;

  logic              v1_r, v2_r, v3_r, v4_r;
  logic              en1, en2, en3, en4;
  logic [PWR_W-1:0]  s1_r, s2_r, s3_r, s4_r;
  logic [PF_W-1:0]   pf1_r;
  logic [PROD_W-1:0] prod2_r;
  logic [PWR_W-1:0]  p3_r, p4_r;
  logic [SQ_W-1:0]   ss3_r, pp3_r, diff4_r;

  logic [PF_W-1:0]   pf_ext;
  logic [PF_W-1:0]   pf1_nxt;
  logic [PWR_W-1:0]  s1_nxt;
  logic [PROD_W-1:0] prod2_nxt;
  logic [PWR_W-1:0]  p3_nxt;
  logic [SQ_W-1:0]   ss3_nxt, pp3_nxt, diff4_nxt;

  // stage advance: a stage moves when empty or when its successor moves
  assign en4      = !v4_r || dn_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  // stage 1: apparent power, power factor clamped to 1.0
  assign pf_ext  = PF_W'(up_power_factor);
  assign pf1_nxt = (pf_ext > PF_ONE) ? PF_ONE : pf_ext;
  assign s1_nxt  = PWR_W'(up_voltage) * PWR_W'(up_current);

  // stage 2: apparent times power factor
  assign prod2_nxt = PROD_W'(s1_r) * PROD_W'(pf1_r);

  // stage 3: drop the fraction, then square both powers
  assign p3_nxt  = prod2_r[FRACTION_BITS +: PWR_W];
  assign ss3_nxt = SQ_W'(s2_r) * SQ_W'(s2_r);
  assign pp3_nxt = SQ_W'(p3_nxt) * SQ_W'(p3_nxt);

  // stage 4: difference of squares, never negative since active <= apparent
  assign diff4_nxt = ss3_r - pp3_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r  <= s1_nxt;
      pf1_r <= pf1_nxt;
    end
    if (en2) begin
      s2_r    <= s1_r;
      prod2_r <= prod2_nxt;
    end
    if (en3) begin
      s3_r  <= s2_r;
      p3_r  <= p3_nxt;
      ss3_r <= ss3_nxt;
      pp3_r <= pp3_nxt;
    end
    if (en4) begin
      s4_r    <= s3_r;
      p4_r    <= p3_r;
      diff4_r <= diff4_nxt;
    end
  end

  assign dn_valid        = v4_r;
  assign dn_diff         = diff4_r;
  assign dn_pwr.apparent = s4_r;
  assign dn_pwr.active   = p4_r;

`ifndef SYNTH
  // the subtraction must never wrap
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> pp3_r <= ss3_r)
    else $error("ptc_front: active squared exceeds apparent squared");
`endif

endmodule : ptc_front

// File: hdl/ptc_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_sqrt_pipe
// Pipelined digit-by-digit integer square root, one root bit per stage,
// with the apparent and active powers carried alongside.
// ----------------------------------------------------------------------------
module ptc_sqrt_pipe
  import ptc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [SQ_W-1:0]  up_radicand,
  input  ptc_pwr_t         up_pwr,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [PWR_W-1:0] dn_root,
  output ptc_pwr_t         dn_pwr
);

  localparam int MID = ROOT_STAGES / 2;

  logic [ROOT_STAGES-1:0] vld_r;
  logic [ROOT_STAGES:0]   en;
  logic [PWR_W-1:0]       root_r [ROOT_STAGES];
  ptc_pwr_t               pwr_r  [ROOT_STAGES];
  logic [REM_W-1:0]       rem_r  [ROOT_STAGES-1];
  logic [SQ_W-1:0]        x_r    [ROOT_STAGES-1];

  assign en[ROOT_STAGES] = dn_ready;
  assign up_ready        = en[0];

  for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] rem_in;
    logic [PWR_W-1:0] root_in;
    logic [SQ_W-1:0]  x_in;
    ptc_pwr_t         pwr_in;
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             ge;
    logic [REM_W-1:0] rem_nxt;
    logic [PWR_W-1:0] root_nxt;

    // stage inputs
    if (k == 0) begin : g_first
      assign v_in    = up_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = up_radicand;
      assign pwr_in  = up_pwr;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign x_in    = x_r[k-1];
      assign pwr_in  = pwr_r[k-1];
    end

    // bring down two radicand bits and try root*4+1
    assign rem_sh   = {rem_in, x_in[SQ_W-1 -: 2]};
    assign trial    = {2'b00, root_in, 2'b01};
    assign ge       = rem_sh >= trial;
    assign rem_nxt  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
    assign root_nxt = {root_in[PWR_W-2:0], ge};

    assign en[k] = !vld_r[k] || en[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en[k]) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        root_r[k] <= root_nxt;
        pwr_r[k]  <= pwr_in;
      end
    end

    // remainder and radicand are not needed past the last stage
    if (k < ROOT_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k] <= rem_nxt;
          x_r[k]   <= {x_in[SQ_W-3:0], 2'b00};
        end
      end
    end
  end

  assign dn_valid = vld_r[ROOT_STAGES-1];
  assign dn_root  = root_r[ROOT_STAGES-1];
  assign dn_pwr   = pwr_r[ROOT_STAGES-1];

`ifndef SYNTH
  // partial remainder stays within 2*root (restoring-root invariant)
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[MID] |-> rem_r[MID] <= {1'b0, root_r[MID], 1'b0})
    else $error("ptc_sqrt_pipe: partial remainder out of range");
`endif

endmodule : ptc_sqrt_pipe

// File: hdl/power_triangle_calc_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_triangle_calc_unit
// Apparent, active and reactive power from RMS voltage, current and power
// factor.
// ----------------------------------------------------------------------------
// Usage:
//   Input word (in_*): voltage (0.1 V), current (mA) and power factor
//   (unsigned, FRACTION_BITS fraction bits, codes above 1.0 clamp to 1.0).
//   Output word (out_*): apparent = V*I, active = (apparent*pf) >> FRACTION_BITS,
//   reactive = floor(sqrt(apparent^2 - active^2)), all in 0.1 mVA.
//   Throughput: one word per clock, sustained while out_tready stays high.
//   Pipeline: from input acceptance to out_tvalid there is one stage for
//   V*I, one for the power factor multiply, one for the two squares, one for
//   the subtraction, 32 square-root stages (one root bit each) and the
//   output register.
//   Stalls: each stage advances when empty or when the stage after it
//   advances, so bubbles close up while out_tready is low; in_tready drops
//   only once every stage holds a word.
//   Reset: rst_n (synchronous, active low) empties the pipeline; words in
//   flight are dropped and out_tvalid goes low.
// ----------------------------------------------------------------------------
module power_triangle_calc_unit
  import ptc_pkg::*;
#(
  parameter int FRACTION_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // voltage[15:0], current[31:16], power_factor[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata   // apparent_power[31:0], active_power[63:32],
                                  // reactive_power[95:64]
);

  logic             fr_valid, fr_ready;
  logic [SQ_W-1:0]  fr_diff;
  ptc_pwr_t         fr_pwr;
  logic             sq_valid, sq_ready;
  logic [PWR_W-1:0] sq_root;
  ptc_pwr_t         sq_pwr;

  logic             out_vld_r;
  logic [95:0]      out_data_r;
  logic [95:0]      out_data_nxt;
  logic             out_en;

  // multiply front end
  ptc_front #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (in_tvalid),
    .up_ready        (in_tready),
    .up_voltage      (in_tdata[15:0]),
    .up_current      (in_tdata[31:16]),
    .up_power_factor (in_tdata[47:32]),
    .dn_valid        (fr_valid),
    .dn_ready        (fr_ready),
    .dn_diff         (fr_diff),
    .dn_pwr          (fr_pwr)
  );

  // square-root pipeline
  ptc_sqrt_pipe u_sqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (fr_valid),
    .up_ready    (fr_ready),
    .up_radicand (fr_diff),
    .up_pwr      (fr_pwr),
    .dn_valid    (sq_valid),
    .dn_ready    (sq_ready),
    .dn_root     (sq_root),
    .dn_pwr      (sq_pwr)
  );

  // output register
  assign out_en       = !out_vld_r || out_tready;
  assign sq_ready     = out_en;
  assign out_data_nxt = {sq_root, sq_pwr.active, sq_pwr.apparent};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_en) begin
      out_vld_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  // active power never exceeds apparent power
  a_active_le_apparent: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_data_r[63:32] <= out_data_r[31:0])
    else $error("power_triangle_calc_unit: active power above apparent power");

  // reactive power never exceeds apparent power
  a_reactive_le_apparent: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_data_r[95:64] <= out_data_r[31:0])
    else $error("power_triangle_calc_unit: reactive power above apparent power");

  // input back-pressure only when the output is stalled with a word
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_vld_r && !out_tready))
    else $error("power_triangle_calc_unit: input stalled without output stall");
`endif

endmodule : power_triangle_calc_unit
